FILE: hw/rtl/dhcpox_pkg.sv
`timescale 1ns / 1ps

package dhcpox_pkg;

    localparam int CodeW = 8;
    localparam int AddrW = 32;
    localparam int FlagW = 4;
    localparam int CfgIdxW = 2;

    localparam logic [CodeW-1:0] CODE_PAD = 8'h00;
    localparam logic [CodeW-1:0] CODE_END = 8'hff;

    localparam logic [CodeW-1:0] TYPE_CODE_RST = 8'd53;
    localparam logic [CodeW-1:0] SERVER_CODE_RST = 8'd54;
    localparam logic [CodeW-1:0] MASK_CODE_RST = 8'd1;
    localparam logic [CodeW-1:0] ROUTER_CODE_RST = 8'd3;

    localparam logic [CfgIdxW-1:0] REG_TYPE_CODE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SERVER_CODE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MASK_CODE = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_ROUTER_CODE = 2'd3;

    localparam int SLOT_TYPE = 0;
    localparam int SLOT_SERVER = 1;
    localparam int SLOT_MASK = 2;
    localparam int SLOT_ROUTER = 3;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CodeW-1:0] opt_byte;
        logic             last_byte;
    } in_word_t;

    typedef struct packed {
        logic [CodeW-1:0] message_type;
        logic [AddrW-1:0] server_addr;
        logic [AddrW-1:0] subnet_mask;
        logic [AddrW-1:0] router_addr;
        logic [FlagW-1:0] found_flags;
        logic             status;
    } out_word_t;

    function automatic logic [AddrW-1:0] put_be(input logic [AddrW-1:0] acc,
                                                input logic [CodeW-1:0] b,
                                                input logic [1:0] idx);
        logic [AddrW-1:0] lane;
        lane = {{(AddrW-CodeW){1'b0}}, b} << (5'd24 - {idx, 3'b000});
        return acc | lane;
    endfunction

endpackage

FILE: hw/rtl/dhcp_option_extractor.sv
`timescale 1ns / 1ps
// the result word is registered from the accepted last byte of a packet and is valid in the cycle after it
// throughput: one option byte per cycle, all parsing done in one combinational pass
// a last byte waits only while the previous result word is still held on m_data
// reset (aresetn low, synchronous): parse state cleared, option codes back to
// 53, 54, 1 and 3, result register empty
module dhcp_option_extractor
    import dhcpox_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CodeW-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    logic [CodeW-1:0] type_code_reg, server_code_reg, mask_code_reg, router_code_reg;

    phase_t           phase_reg, phase_next;
    logic [CodeW-1:0] cur_code_reg, cur_code_next;
    logic [CodeW-1:0] bytes_left_reg, bytes_left_next;
    logic [2:0]       value_index_reg, value_index_next;
    logic [CodeW-1:0] type_value_reg, type_value_next;
    logic [AddrW-1:0] server_value_reg, server_value_next;
    logic [AddrW-1:0] mask_value_reg, mask_value_next;
    logic [AddrW-1:0] router_value_reg, router_value_next;
    logic [FlagW-1:0] found_mask_reg, found_mask_next;
    logic             end_seen_reg, end_seen_next;
    logic [FlagW-1:0] capture_reg, capture_next;

    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             in_fire;
    logic             last_fire;
    logic [FlagW-1:0] hit;
    logic [CodeW-1:0] b;

    assign b = s_data.opt_byte;
    assign s_ready = !m_valid_reg || m_ready || !s_data.last_byte;
    assign in_fire = s_valid && s_ready;
    assign last_fire = in_fire && s_data.last_byte;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_comb begin
        hit[SLOT_TYPE] = (cur_code_reg == type_code_reg);
        hit[SLOT_SERVER] = (cur_code_reg == server_code_reg);
        hit[SLOT_MASK] = (cur_code_reg == mask_code_reg);
        hit[SLOT_ROUTER] = (cur_code_reg == router_code_reg);
    end

    always_comb begin
        phase_next = phase_reg;
        cur_code_next = cur_code_reg;
        bytes_left_next = bytes_left_reg;
        value_index_next = value_index_reg;
        type_value_next = type_value_reg;
        server_value_next = server_value_reg;
        mask_value_next = mask_value_reg;
        router_value_next = router_value_reg;
        found_mask_next = found_mask_reg;
        end_seen_next = end_seen_reg;
        capture_next = capture_reg;
        unique case (phase_reg)
            PH_CODE: begin
                if (b == CODE_END) begin
                    end_seen_next = 1'b1;
                    phase_next = PH_DONE;
                end else if (b != CODE_PAD) begin
                    cur_code_next = b;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                found_mask_next = found_mask_reg | (hit & ~found_mask_reg);
                bytes_left_next = b;
                value_index_next = 3'd0;
                if (b == '0) begin
                    capture_next = '0;
                    phase_next = PH_CODE;
                end else begin
                    capture_next = hit & ~found_mask_reg;
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (!value_index_reg[2]) begin
                    if (capture_reg[SLOT_TYPE] && value_index_reg == 3'd0) begin
                        type_value_next = b;
                    end
                    if (capture_reg[SLOT_SERVER]) begin
                        server_value_next = put_be(server_value_reg, b, value_index_reg[1:0]);
                    end
                    if (capture_reg[SLOT_MASK]) begin
                        mask_value_next = put_be(mask_value_reg, b, value_index_reg[1:0]);
                    end
                    if (capture_reg[SLOT_ROUTER]) begin
                        router_value_next = put_be(router_value_reg, b, value_index_reg[1:0]);
                    end
                    value_index_next = value_index_reg + 3'd1;
                end
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    capture_next = '0;
                    phase_next = PH_CODE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_code_reg <= TYPE_CODE_RST;
            server_code_reg <= SERVER_CODE_RST;
            mask_code_reg <= MASK_CODE_RST;
            router_code_reg <= ROUTER_CODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TYPE_CODE:   type_code_reg <= cfg_wdata;
                REG_SERVER_CODE: server_code_reg <= cfg_wdata;
                REG_MASK_CODE:   mask_code_reg <= cfg_wdata;
                REG_ROUTER_CODE: router_code_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || last_fire) begin
            phase_reg <= PH_CODE;
            cur_code_reg <= '0;
            bytes_left_reg <= '0;
            value_index_reg <= '0;
            type_value_reg <= '0;
            server_value_reg <= '0;
            mask_value_reg <= '0;
            router_value_reg <= '0;
            found_mask_reg <= '0;
            end_seen_reg <= 1'b0;
            capture_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            cur_code_reg <= cur_code_next;
            bytes_left_reg <= bytes_left_next;
            value_index_reg <= value_index_next;
            type_value_reg <= type_value_next;
            server_value_reg <= server_value_next;
            mask_value_reg <= mask_value_next;
            router_value_reg <= router_value_next;
            found_mask_reg <= found_mask_next;
            end_seen_reg <= end_seen_next;
            capture_reg <= capture_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_fire) begin
            m_data_reg.message_type <= type_value_next;
            m_data_reg.server_addr <= server_value_next;
            m_data_reg.subnet_mask <= mask_value_next;
            m_data_reg.router_addr <= router_value_next;
            m_data_reg.found_flags <= found_mask_next;
            m_data_reg.status <= !end_seen_next;
        end
    end

    a_done_means_end : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) == end_seen_reg)
        else $error("end flag and done phase disagree");

    a_capture_in_value : assert property (@(posedge aclk) disable iff (!aresetn)
        (capture_reg != '0) |-> (phase_reg == PH_VALUE))
        else $error("capture active outside value phase");

    a_capture_found : assert property (@(posedge aclk) disable iff (!aresetn)
        (capture_reg & ~found_mask_reg) == '0)
        else $error("capturing a slot not marked found");

    a_index_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        value_index_reg <= 3'd4)
        else $error("value index past saturation");

    a_last_gives_word : assert property (@(posedge aclk) disable iff (!aresetn)
        last_fire |=> (m_valid_reg && phase_reg == PH_CODE && found_mask_reg == '0))
        else $error("last byte did not produce a word and clear state");

endmodule
